// ===== sv/psvm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvm_pkg
// Shared types, codes and constants of the sample playback voice mixer.
// ----------------------------------------------------------------------------
package psvm_pkg;

    // Default sizes
    localparam int VOICE_COUNT_DEF  = 16;
    localparam int NUM_KEYS_DEF     = 19;
    localparam int SAMPLE_DEPTH_DEF = 65536;

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int ADDR_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int KEY_W    = 5;
    localparam int LEN_W    = 17;
    localparam int GAIN_W   = 13;
    localparam int LEVEL_W  = 7;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_KEY  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PLAY_KEY = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PLAY_BGM = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_STOP_BGM = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BGM    = 2'd2;

    // Levels and gains
    localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 7'd100;
    localparam logic [LEVEL_W-1:0] MASTER_RESET     = 7'd80;
    localparam logic [LEVEL_W-1:0] KEY_LEVEL_RESET  = 7'd80;
    localparam logic [LEVEL_W-1:0] BGM_LEVEL_RESET  = 7'd75;
    localparam logic [GAIN_W-1:0]  GAIN_ONE         = 13'd4096;
    localparam int                 GAIN_SHIFT       = 12;

    // Divide by 10000: floor(m * RECIP / 2^32) is q or q-1 for m < 2^29
    localparam int                 MAG_W    = 29;
    localparam int                 QUOT_W   = 16;
    localparam logic [18:0]        RECIP    = 19'd429496;
    localparam int                 RECIP_SHIFT = 32;
    localparam logic [MAG_W-1:0]   DIVISOR  = 29'd10000;

    // Product widths
    localparam int P1_W = 24;
    localparam int P2_W = 31;
    localparam int P3_W = 44;

    // Controller to datapath commands
    typedef struct packed {
        logic exec_op;
        logic clear_acc;
        logic scan;
        logic mul1;
        logic mul2;
        logic mul3;
        logic absval;
        logic div1;
        logic div2;
        logic acc;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic voice_hit;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

// ===== sv/polyphonic_sample_voice_mixer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_sample_voice_mixer_unit
// Sixteen-voice sample playback mixer over a 16-bit sample memory.
//
// The input channel (in_valid / in_stall) carries one command beat: write a
// sample word, define a key, start a key, start or stop the background voice,
// or tick. All commands but tick are taken without a stall and the next beat
// may follow at once. A tick visits every voice in turn: an idle voice is only
// scanned, while an active one passes the steps memory read, three gain
// multiplies, magnitude, reciprocal multiply, remainder check and accumulate;
// then the result is loaded. The input is stalled until the tick ends. A tick
// with at least one active voice places one beat on the output channel
// (out_valid / out_stall); the output register holds it while out_stall is
// high and the next command is still taken; a tick that completes while the
// result waits holds in its last step. Configuration writes (cfg_write_en,
// cfg_index, cfg_data) take effect at once and clamp levels above 100. Reset
// stops all voices, clears key lengths and loads default levels; sample
// memory contents are kept. SAMPLE_DEPTH is a power of two.
// ----------------------------------------------------------------------------
module polyphonic_sample_voice_mixer_unit #(
    parameter int VOICE_COUNT  = psvm_pkg::VOICE_COUNT_DEF,
    parameter int NUM_KEYS     = psvm_pkg::NUM_KEYS_DEF,
    parameter int SAMPLE_DEPTH = psvm_pkg::SAMPLE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write_en,
    input  wire logic [psvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [psvm_pkg::LEVEL_W-1:0]         cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [psvm_pkg::FUNC_W-1:0]          func,
    input  wire logic [psvm_pkg::ADDR_W-1:0]          address,
    input  wire logic signed [psvm_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic [psvm_pkg::KEY_W-1:0]           key_index,
    input  wire logic [psvm_pkg::LEN_W-1:0]           length,
    input  wire logic [psvm_pkg::GAIN_W-1:0]          bgm_gain,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [psvm_pkg::SAMPLE_W-1:0]      mixed_sample,
    output logic [psvm_pkg::COUNT_W-1:0]              voices_active
);

    localparam int VIW = $clog2(VOICE_COUNT);

    psvm_pkg::cmd_t    cmd;
    psvm_pkg::status_t status;
    logic [VIW-1:0]    vidx;

    psvm_ctrl #(
        .VOICE_COUNT (VOICE_COUNT),
        .VIW         (VIW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .cmd      (cmd),
        .status   (status),
        .vidx     (vidx)
    );

    psvm_datapath #(
        .VOICE_COUNT  (VOICE_COUNT),
        .NUM_KEYS     (NUM_KEYS),
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .VIW          (VIW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .vidx          (vidx),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .address       (address),
        .sample_value  (sample_value),
        .key_index     (key_index),
        .length        (length),
        .bgm_gain      (bgm_gain),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mixed_sample  (mixed_sample),
        .voices_active (voices_active)
    );

    // A tick beat stalls the input while voices are visited
    a_tick_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == psvm_pkg::FUNC_TICK |=> in_stall)
        else $error("tick did not stall input");

    // Other commands do not stall the input
    a_op_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func != psvm_pkg::FUNC_TICK |=> !in_stall)
        else $error("command held the input");

    // A new result beat appears only at the end of a tick
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && !in_stall)
        else $error("result outside a tick");

endmodule
`default_nettype wire

// ===== sv/psvm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvm_ctrl
// Controller: takes items, sequences the per-voice mix steps of a tick.
// ----------------------------------------------------------------------------
module psvm_ctrl #(
    parameter int VOICE_COUNT = psvm_pkg::VOICE_COUNT_DEF,
    parameter int VIW = $clog2(VOICE_COUNT)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [psvm_pkg::FUNC_W-1:0]   func,
    output psvm_pkg::cmd_t                     cmd,
    input  wire psvm_pkg::status_t             status,
    output logic [VIW-1:0]                     vidx
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SCAN = 4'd1;
    localparam logic [3:0] ST_MUL1 = 4'd2;
    localparam logic [3:0] ST_MUL2 = 4'd3;
    localparam logic [3:0] ST_MUL3 = 4'd4;
    localparam logic [3:0] ST_ABS  = 4'd5;
    localparam logic [3:0] ST_DIV1 = 4'd6;
    localparam logic [3:0] ST_DIV2 = 4'd7;
    localparam logic [3:0] ST_ACC  = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]     state_reg, state_next;
    logic [VIW-1:0] vidx_reg, vidx_next;
    logic           accept;
    logic           last;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign last     = (vidx_reg == VIW'(VOICE_COUNT - 1));
    assign vidx     = vidx_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        vidx_next  = vidx_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == psvm_pkg::FUNC_TICK)
                    begin
                        cmd.clear_acc = 1'b1;
                        vidx_next     = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        cmd.exec_op = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.voice_hit)
                begin
                    state_next = ST_MUL1;
                end
                else if (last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.absval = 1'b1;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.div1   = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.div2   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vidx_reg  <= vidx_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/psvm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvm_datapath
// Sample memory, key and voice tables, gain multiply, divide and mix sum.
// ----------------------------------------------------------------------------
module psvm_datapath #(
    parameter int VOICE_COUNT  = psvm_pkg::VOICE_COUNT_DEF,
    parameter int NUM_KEYS     = psvm_pkg::NUM_KEYS_DEF,
    parameter int SAMPLE_DEPTH = psvm_pkg::SAMPLE_DEPTH_DEF,
    parameter int VIW = $clog2(VOICE_COUNT)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire psvm_pkg::cmd_t                       cmd,
    output psvm_pkg::status_t                         status,
    input  wire logic [VIW-1:0]                       vidx,
    input  wire logic                                 cfg_write_en,
    input  wire logic [psvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [psvm_pkg::LEVEL_W-1:0]         cfg_data,
    input  wire logic [psvm_pkg::FUNC_W-1:0]          func,
    input  wire logic [psvm_pkg::ADDR_W-1:0]          address,
    input  wire logic signed [psvm_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic [psvm_pkg::KEY_W-1:0]           key_index,
    input  wire logic [psvm_pkg::LEN_W-1:0]           length,
    input  wire logic [psvm_pkg::GAIN_W-1:0]          bgm_gain,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [psvm_pkg::SAMPLE_W-1:0]      mixed_sample,
    output logic [psvm_pkg::COUNT_W-1:0]              voices_active
);

    // Memory index bits; depth is a power of two so wrap is a mask
    localparam int AW  = $clog2(SAMPLE_DEPTH);
    localparam int KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CW  = $clog2(VOICE_COUNT + 1);
    localparam int SW  = 17 + VIW;
    localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);

    localparam int LVW = psvm_pkg::LEVEL_W;
    localparam int LNW = psvm_pkg::LEN_W;

    // Configuration levels
    logic [LVW-1:0] master_reg, key_level_reg, bgm_level_reg;
    logic [LVW-1:0] cfg_clamped;

    // Key table
    logic [psvm_pkg::ADDR_W-1:0] key_start_mem [NUM_KEYS];
    logic [LNW-1:0]              key_length_reg [NUM_KEYS];

    // Voice table
    logic                        voice_active_reg [VOICE_COUNT];
    logic [psvm_pkg::ADDR_W-1:0] voice_start_reg  [VOICE_COUNT];
    logic [LNW-1:0]              voice_length_reg [VOICE_COUNT];
    logic [LNW-1:0]              voice_pos_reg    [VOICE_COUNT];
    logic [LVW-1:0]              voice_level_reg  [VOICE_COUNT];
    logic [psvm_pkg::GAIN_W-1:0] bgm_base_reg;

    // Sample memory
    logic signed [psvm_pkg::SAMPLE_W-1:0] sample_mem [SAMPLE_DEPTH];
    logic signed [psvm_pkg::SAMPLE_W-1:0] rd_data_reg;

    // Mix path
    logic                               is_bgm_reg;
    logic [LVW-1:0]                     level_reg;
    logic signed [psvm_pkg::P1_W-1:0]   p1_reg, p1_next;
    logic signed [psvm_pkg::P2_W-1:0]   p2_reg, p2_next;
    logic signed [psvm_pkg::P3_W-1:0]   p3_reg, p3_next, p3_bgm;
    logic [psvm_pkg::P3_W-1:0]          p3_abs;
    logic [psvm_pkg::MAG_W-1:0]         mag_reg;
    logic                               neg_reg;
    logic [47:0]                        recip_prod;
    logic [psvm_pkg::QUOT_W-1:0]        q0_reg;
    logic [psvm_pkg::MAG_W-1:0]         rem_reg, rem_next;
    logic [psvm_pkg::QUOT_W-1:0]        quot;
    logic signed [SW-1:0]               sum_reg, sum_term;
    logic [CW-1:0]                      count_reg;
    logic signed [psvm_pkg::SAMPLE_W-1:0] sat_value;
    logic [CW+4:0]                      count_ext;

    logic                               out_valid_reg;
    logic signed [psvm_pkg::SAMPLE_W-1:0] mixed_reg;
    logic [psvm_pkg::COUNT_W-1:0]       count_out_reg;

    // Decode
    logic                  key_ok;
    logic [KIW-1:0]        kidx;
    logic [KIW+4:0]        kidx_ext;
    logic [VIW-1:0]        found;
    logic [AW-1:0]         wr_idx;
    logic [AW+15:0]        wr_ext;
    logic [AW+17:0]        rd_full;
    logic                  voice_live;
    logic                  voice_hit;
    logic [LNW-1:0]        cur_pos, pos_inc;

    assign kidx_ext = (KIW + 5)'(key_index);
    assign kidx     = kidx_ext[KIW-1:0];
    assign key_ok   = (32'(key_index) < NUM_KEYS);
    assign wr_ext   = (AW + 16)'(address);
    assign wr_idx   = wr_ext[AW-1:0];

    assign cfg_clamped = (cfg_data > psvm_pkg::LEVEL_MAX) ? psvm_pkg::LEVEL_MAX : cfg_data;

    // First idle key voice, else voice one
    always_comb
    begin
        found = VIW'(1);
        for (int v = VOICE_COUNT - 1; v >= 1; v--)
        begin
            if (!voice_active_reg[v])
            begin
                found = VIW'(v);
            end
        end
    end

    // Current voice lookup
    assign cur_pos    = voice_pos_reg[vidx];
    assign pos_inc    = cur_pos + 1'b1;
    assign voice_live = voice_active_reg[vidx];
    assign voice_hit  = voice_live && (cur_pos < voice_length_reg[vidx]);
    assign rd_full    = (AW + 18)'(voice_start_reg[vidx]) + (AW + 18)'(cur_pos);

    assign status.voice_hit = voice_hit;
    assign status.out_busy  = out_valid_reg && out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg    <= psvm_pkg::MASTER_RESET;
            key_level_reg <= psvm_pkg::KEY_LEVEL_RESET;
            bgm_level_reg <= psvm_pkg::BGM_LEVEL_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                psvm_pkg::CFG_MASTER: master_reg    <= cfg_clamped;
                psvm_pkg::CFG_KEY:    key_level_reg <= cfg_clamped;
                psvm_pkg::CFG_BGM:    bgm_level_reg <= cfg_clamped;
                default:              ;
            endcase
        end
    end

    // Key lengths: reset to no sound
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                key_length_reg[k] <= '0;
            end
        end
        else if (cmd.exec_op && func == psvm_pkg::FUNC_SET_KEY && key_ok)
        begin
            key_length_reg[kidx] <= length;
        end
    end

    // Key start addresses
    always_ff @(posedge clk)
    begin
        if (cmd.exec_op && func == psvm_pkg::FUNC_SET_KEY && key_ok)
        begin
            key_start_mem[kidx] <= address;
        end
    end

    // Voice activity and background base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                voice_active_reg[v] <= 1'b0;
            end
            bgm_base_reg <= psvm_pkg::GAIN_ONE;
        end
        else if (cmd.exec_op)
        begin
            case (func)
                psvm_pkg::FUNC_PLAY_KEY:
                begin
                    if (key_ok && key_length_reg[kidx] != '0)
                    begin
                        voice_active_reg[found] <= 1'b1;
                    end
                end
                psvm_pkg::FUNC_PLAY_BGM:
                begin
                    voice_active_reg[0] <= (length != '0);
                    bgm_base_reg <= (bgm_gain > psvm_pkg::GAIN_ONE) ?
                                    psvm_pkg::GAIN_ONE : bgm_gain;
                end
                psvm_pkg::FUNC_STOP_BGM:
                begin
                    voice_active_reg[0] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.scan && voice_live)
        begin
            // drop a voice that has played its last sample
            if (!voice_hit || pos_inc >= voice_length_reg[vidx])
            begin
                voice_active_reg[vidx] <= 1'b0;
            end
        end
    end

    // Voice payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec_op && func == psvm_pkg::FUNC_PLAY_KEY && key_ok
            && key_length_reg[kidx] != '0)
        begin
            voice_start_reg[found]  <= key_start_mem[kidx];
            voice_length_reg[found] <= key_length_reg[kidx];
            voice_pos_reg[found]    <= '0;
            voice_level_reg[found]  <= key_level_reg;
        end
        else if (cmd.exec_op && func == psvm_pkg::FUNC_PLAY_BGM && length != '0)
        begin
            voice_start_reg[0]  <= address;
            voice_length_reg[0] <= length;
            voice_pos_reg[0]    <= '0;
            voice_level_reg[0]  <= '0;
        end
        else if (cmd.scan && voice_hit)
        begin
            voice_pos_reg[vidx] <= pos_inc;
        end
    end

    // Sample memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec_op && func == psvm_pkg::FUNC_WRITE)
        begin
            sample_mem[wr_idx] <= sample_value;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= sample_mem[rd_full[AW-1:0]];
        end
    end

    // Gain products
    assign p1_next = rd_data_reg * $signed({1'b0, master_reg});
    assign p2_next = p1_reg * $signed({1'b0, level_reg});
    assign p3_bgm  = p2_reg * $signed({1'b0, bgm_base_reg});
    assign p3_next = is_bgm_reg ? p3_bgm : psvm_pkg::P3_W'(p2_reg);
    assign p3_abs  = p3_reg[psvm_pkg::P3_W-1] ? psvm_pkg::P3_W'(-p3_reg)
                                              : psvm_pkg::P3_W'(p3_reg);

    // Divide by 10000 through the reciprocal, then correct by one
    assign recip_prod = mag_reg * psvm_pkg::RECIP;
    assign rem_next   = mag_reg - q0_reg * psvm_pkg::DIVISOR;
    assign quot       = q0_reg + psvm_pkg::QUOT_W'(rem_reg >= psvm_pkg::DIVISOR);
    assign sum_term   = neg_reg ? -SW'(quot) : SW'(quot);

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            is_bgm_reg <= (vidx == '0);
            level_reg  <= (vidx == '0) ? bgm_level_reg : voice_level_reg[vidx];
        end
        if (cmd.mul1)
        begin
            p1_reg <= p1_next;
        end
        if (cmd.mul2)
        begin
            p2_reg <= p2_next;
        end
        if (cmd.mul3)
        begin
            p3_reg <= p3_next;
        end
        if (cmd.absval)
        begin
            neg_reg <= p3_reg[psvm_pkg::P3_W-1];
            mag_reg <= is_bgm_reg ? psvm_pkg::MAG_W'(p3_abs >> psvm_pkg::GAIN_SHIFT)
                                  : psvm_pkg::MAG_W'(p3_abs);
        end
        if (cmd.div1)
        begin
            q0_reg <= recip_prod[psvm_pkg::RECIP_SHIFT +: psvm_pkg::QUOT_W];
        end
        if (cmd.div2)
        begin
            rem_reg <= rem_next;
        end
    end

    // Running sum and voice count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.clear_acc)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.scan && voice_hit)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.acc)
            begin
                sum_reg <= sum_reg + sum_term;
            end
        end
    end

    // Saturate to 16 bits
    always_comb
    begin
        if (sum_reg > SAT_HI)
        begin
            sat_value = 16'sh7FFF;
        end
        else if (sum_reg < SAT_LO)
        begin
            sat_value = 16'sh8000;
        end
        else
        begin
            sat_value = sum_reg[psvm_pkg::SAMPLE_W-1:0];
        end
    end

    assign count_ext = (CW + 5)'(count_reg);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= (count_reg != '0);
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            mixed_reg     <= sat_value;
            count_out_reg <= count_ext[psvm_pkg::COUNT_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign mixed_sample  = mixed_reg;
    assign voices_active = count_out_reg;

endmodule
`default_nettype wire
